// ----- design/c128b_pkg.sv -----
// shared types, constants and pattern tables for the code 128 set b encoder
package c128b_pkg;

	localparam int QueueDepth = 4;

	// symbol arithmetic
	localparam logic [6:0] CheckMod = 7'd103;
	localparam logic [6:0] CheckReset = 7'd1;      // start b value 104 taken mod 103
	localparam logic [6:0] CharBase = 7'd32;
	localparam logic [13:0] RecipMod = 14'd10180;  // floor(2^20 / 103)
	localparam int RecipShift = 20;

	// fixed patterns, one hex digit per element, first element in the top digit
	localparam logic [23:0] StartBPat = 24'h211214;
	localparam logic [27:0] StopPat = 28'h2331112;

	// one queued word: a classified character with its finished checksum
	typedef struct packed {
		logic       first;
		logic       last;
		logic       bad;
		logic [6:0] value;
		logic [6:0] chk;
	} entry_t;

	// six module counts of a symbol value
	function automatic logic [23:0] sym_pat(input logic [6:0] v);
		logic [23:0] p;
		begin
			unique case (v)
				7'd0: p = 24'h212222;   7'd1: p = 24'h222122;   7'd2: p = 24'h222221;
				7'd3: p = 24'h121223;   7'd4: p = 24'h121322;   7'd5: p = 24'h131222;
				7'd6: p = 24'h122213;   7'd7: p = 24'h122312;   7'd8: p = 24'h132212;
				7'd9: p = 24'h221213;   7'd10: p = 24'h221312;  7'd11: p = 24'h231212;
				7'd12: p = 24'h112232;  7'd13: p = 24'h122132;  7'd14: p = 24'h122231;
				7'd15: p = 24'h113222;  7'd16: p = 24'h123122;  7'd17: p = 24'h123221;
				7'd18: p = 24'h223211;  7'd19: p = 24'h221132;  7'd20: p = 24'h221231;
				7'd21: p = 24'h213212;  7'd22: p = 24'h223112;  7'd23: p = 24'h312131;
				7'd24: p = 24'h311222;  7'd25: p = 24'h321122;  7'd26: p = 24'h321221;
				7'd27: p = 24'h312212;  7'd28: p = 24'h322112;  7'd29: p = 24'h322211;
				7'd30: p = 24'h212123;  7'd31: p = 24'h212321;  7'd32: p = 24'h232121;
				7'd33: p = 24'h111323;  7'd34: p = 24'h131123;  7'd35: p = 24'h131321;
				7'd36: p = 24'h112313;  7'd37: p = 24'h132113;  7'd38: p = 24'h132311;
				7'd39: p = 24'h211313;  7'd40: p = 24'h231113;  7'd41: p = 24'h231311;
				7'd42: p = 24'h112133;  7'd43: p = 24'h112331;  7'd44: p = 24'h132131;
				7'd45: p = 24'h113123;  7'd46: p = 24'h113321;  7'd47: p = 24'h133121;
				7'd48: p = 24'h313121;  7'd49: p = 24'h211331;  7'd50: p = 24'h231131;
				7'd51: p = 24'h213113;  7'd52: p = 24'h213311;  7'd53: p = 24'h213131;
				7'd54: p = 24'h311123;  7'd55: p = 24'h311321;  7'd56: p = 24'h331121;
				7'd57: p = 24'h312113;  7'd58: p = 24'h312311;  7'd59: p = 24'h332111;
				7'd60: p = 24'h314111;  7'd61: p = 24'h221411;  7'd62: p = 24'h431111;
				7'd63: p = 24'h111224;  7'd64: p = 24'h111422;  7'd65: p = 24'h121124;
				7'd66: p = 24'h121421;  7'd67: p = 24'h141122;  7'd68: p = 24'h141221;
				7'd69: p = 24'h112214;  7'd70: p = 24'h112412;  7'd71: p = 24'h122114;
				7'd72: p = 24'h122411;  7'd73: p = 24'h142112;  7'd74: p = 24'h142211;
				7'd75: p = 24'h241211;  7'd76: p = 24'h221114;  7'd77: p = 24'h413111;
				7'd78: p = 24'h241112;  7'd79: p = 24'h134111;  7'd80: p = 24'h111242;
				7'd81: p = 24'h121142;  7'd82: p = 24'h121241;  7'd83: p = 24'h114212;
				7'd84: p = 24'h124112;  7'd85: p = 24'h124211;  7'd86: p = 24'h411212;
				7'd87: p = 24'h421112;  7'd88: p = 24'h421211;  7'd89: p = 24'h212141;
				7'd90: p = 24'h214121;  7'd91: p = 24'h412121;  7'd92: p = 24'h111143;
				7'd93: p = 24'h111341;  7'd94: p = 24'h131141;  7'd95: p = 24'h114113;
				7'd96: p = 24'h114311;  7'd97: p = 24'h411113;  7'd98: p = 24'h411311;
				7'd99: p = 24'h113141;  7'd100: p = 24'h114131; 7'd101: p = 24'h311141;
				7'd102: p = 24'h411131;
				default: p = 24'h212222;
			endcase
			return p;
		end
	endfunction

endpackage

// ----- design/c128b_front.sv -----
// front end: classifies characters and runs the checksum pipeline
module c128b_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [6:0]         char_code,
	input  logic               first_char,
	input  logic               last_char,
	output logic               push,
	input  logic               full,
	output c128b_pkg::entry_t  push_entry
);

	logic v1_s1, v2_s2, v3_s3;
	logic en1, en2, en3;
	logic [6:0] pw_q, acc_q;
	logic [6:0] pw_cur, pw_next;
	logic char_ok;
	logic [6:0] val_in;
	logic [13:0] prod;
	logic [27:0] qprod;
	logic [13:0] rem_raw, rem_fix;
	logic [7:0] sum;
	logic [6:0] base, chk;

	// stage payloads
	logic first_s1, last_s1, bad_s1;
	logic [6:0] val_s1;
	logic [13:0] p_s1;
	logic first_s2, last_s2, bad_s2;
	logic [6:0] val_s2, q_s2;
	logic [13:0] p_s2;
	logic first_s3, last_s3, bad_s3;
	logic [6:0] val_s3, r_s3;

	// stall chain
	assign en3 = !v3_s3 || !full;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign in_ready = en1;
	assign push = v3_s3 && !full;

	// classify and weight by position
	assign char_ok = (char_code >= c128b_pkg::CharBase) && (char_code != 7'd127);
	assign val_in = char_ok ? (char_code - c128b_pkg::CharBase) : 7'd0;
	assign pw_cur = first_char ? 7'd1 : pw_q;
	assign prod = {7'd0, pw_cur} * {7'd0, val_in};

	always_comb begin
		if (last_char)
			pw_next = 7'd1;
		else if (pw_cur == c128b_pkg::CheckMod - 7'd1)
			pw_next = 7'd0;
		else
			pw_next = pw_cur + 7'd1;
	end

	// reciprocal quotient estimate, never above the true quotient
	assign qprod = p_s1 * c128b_pkg::RecipMod;

	// remainder with one correction step
	assign rem_raw = p_s2 - ({7'd0, q_s2} * {7'd0, c128b_pkg::CheckMod});
	assign rem_fix = (rem_raw >= 14'(c128b_pkg::CheckMod))
		? rem_raw - 14'(c128b_pkg::CheckMod) : rem_raw;

	// running checksum
	assign base = first_s3 ? c128b_pkg::CheckReset : acc_q;
	assign sum = {1'b0, base} + {1'b0, r_s3};
	assign chk = (sum >= {1'b0, c128b_pkg::CheckMod})
		? 7'(sum - {1'b0, c128b_pkg::CheckMod}) : sum[6:0];

	always_comb begin
		push_entry.first = first_s3;
		push_entry.last = last_s3;
		push_entry.bad = bad_s3;
		push_entry.value = val_s3;
		push_entry.chk = chk;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			pw_q <= 7'd1;
			acc_q <= c128b_pkg::CheckReset;
		end else begin
			if (en1) v1_s1 <= in_valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (in_valid && in_ready) pw_q <= pw_next;
			if (push) acc_q <= last_s3 ? c128b_pkg::CheckReset : chk;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en1) begin
			first_s1 <= first_char;
			last_s1 <= last_char;
			bad_s1 <= !char_ok;
			val_s1 <= val_in;
			p_s1 <= prod;
		end
		if (en2) begin
			first_s2 <= first_s1;
			last_s2 <= last_s1;
			bad_s2 <= bad_s1;
			val_s2 <= val_s1;
			p_s2 <= p_s1;
			q_s2 <= qprod[c128b_pkg::RecipShift +: 7];
		end
		if (en3) begin
			first_s3 <= first_s2;
			last_s3 <= last_s2;
			bad_s3 <= bad_s2;
			val_s3 <= val_s2;
			r_s3 <= rem_fix[6:0];
		end
	end

	// checksum state stays reduced
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q < c128b_pkg::CheckMod)
		else $error("checksum accumulator out of range");
	a_pw_range: assert property (@(posedge clk) disable iff (!arst_n)
		pw_q < c128b_pkg::CheckMod)
		else $error("position weight out of range");
	a_push_rem: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> r_s3 < c128b_pkg::CheckMod)
		else $error("remainder not reduced");

endmodule

// ----- design/c128b_fifo.sv -----
// short queue between front and back ends
module c128b_fifo #(
	parameter int DEPTH = c128b_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  c128b_pkg::entry_t  push_entry,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output c128b_pkg::entry_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	c128b_pkg::entry_t mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

// ----- design/c128b_back.sv -----
// back end: walks the start, character, checksum and stop patterns
module c128b_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         module_width,
	input  logic               empty,
	input  c128b_pkg::entry_t  head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         element_width,
	output logic               is_bar,
	output logic               end_of_code,
	output logic               bad_char,
	output logic               last_of_run
);

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_CHAR  = 2'd1;
	localparam logic [1:0] PH_CHECK = 2'd2;
	localparam logic [1:0] PH_STOP  = 2'd3;

	logic busy_q;
	logic [1:0] phase_q, phase;
	logic [2:0] idx_q, idx;
	logic valid_q;
	logic step;
	logic [23:0] sym;
	logic [3:0] digit;
	logic [3:0] mw_eff;
	logic [6:0] wprod;
	logic bad_elem, eoc_elem, phase_end, run_end;
	logic [1:0] phase_after;

	assign phase = busy_q ? phase_q : (head.first ? PH_START : PH_CHAR);
	assign idx = busy_q ? idx_q : 3'd0;
	assign step = !empty && (!valid_q || out_ready);
	assign out_valid = valid_q;

	// module count of the current element
	assign sym = c128b_pkg::sym_pat((phase == PH_CHECK) ? head.chk : head.value);
	always_comb begin
		unique case (phase)
			PH_START: digit = c128b_pkg::StartBPat[23 - 4*idx -: 4];
			PH_STOP:  digit = c128b_pkg::StopPat[27 - 4*idx -: 4];
			default:  digit = sym[23 - 4*idx -: 4];
		endcase
	end

	assign mw_eff = (module_width == 4'd0) ? 4'd1 : module_width;
	assign wprod = digit[2:0] * mw_eff;

	// element flags and phase sequencing
	assign bad_elem = (phase == PH_CHAR) && head.bad;
	assign eoc_elem = (phase == PH_STOP) && (idx == 3'd6);
	always_comb begin
		unique case (phase)
			PH_STOP: phase_end = (idx == 3'd6);
			PH_CHAR: phase_end = head.bad || (idx == 3'd5);
			default: phase_end = (idx == 3'd5);
		endcase
	end
	always_comb begin
		unique case (phase)
			PH_START: phase_after = PH_CHAR;
			PH_CHAR:  phase_after = PH_CHECK;
			PH_CHECK: phase_after = PH_STOP;
			default:  phase_after = PH_START;
		endcase
	end
	assign run_end = phase_end && ((phase == PH_STOP) || ((phase == PH_CHAR) && !head.last));
	assign pop = step && run_end;

	// sequencer and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= PH_START;
			idx_q <= 3'd0;
			valid_q <= 1'b0;
		end else begin
			if (step) begin
				valid_q <= 1'b1;
				if (run_end) begin
					busy_q <= 1'b0;
					idx_q <= 3'd0;
				end else if (phase_end) begin
					busy_q <= 1'b1;
					phase_q <= phase_after;
					idx_q <= 3'd0;
				end else begin
					busy_q <= 1'b1;
					phase_q <= phase;
					idx_q <= idx + 3'd1;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (step) begin
			element_width <= bad_elem ? 6'd0 : wprod[5:0];
			is_bar <= !bad_elem && !idx[0];
			end_of_code <= eoc_elem;
			bad_char <= bad_elem;
			last_of_run <= run_end;
		end
	end

	a_eoc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_code |-> last_of_run)
		else $error("end of code not marked last of run");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_char |-> element_width == 6'd0 && !is_bar)
		else $error("error word carries a width");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= 3'd6) && (phase_q == PH_STOP || idx_q <= 3'd5))
		else $error("element index out of range");

endmodule

// ----- design/code128b_bar_encoder.sv -----
// top level of the code 128 set b bar encoder
// Code 128 set B encoder: each accepted character word yields its bar/space elements on the
// master side, one element per cycle while m_tready is high. A plain character gives 6
// elements, an invalid one a single error word with zero width; a first mark adds the 6
// start B elements before it, a last mark adds the 6 checksum elements and 7 stop elements
// after it, so one word yields 1 to 25 elements. The back end sequencer sets the sustained
// rate of one element per cycle while a word is queued and m_tready is high. The front end
// takes one word per cycle unless the queue backs up, through a three-stage checksum
// pipeline into a queue of QUEUE_DEPTH words, so input and output stall independently; a
// word passes the stage registers and the queue before the output register. module_width is
// read live by the back end; the user must write it only while idle, which is not enforced.
module code128b_bar_encoder #(
	parameter int QUEUE_DEPTH = c128b_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data,     // module_width
	// character input
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,      // [6:0] char_code, [7] zero
	input  logic [0:0] s_tuser,      // [0] first_char
	input  logic       s_tlast,      // last_char
	// element output
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,      // [5:0] element_width, [7:6] zero
	output logic [2:0] m_tuser,      // [0] is_bar, [1] end_of_code, [2] bad_char
	output logic       m_tlast       // last_of_run
);

	logic [3:0] mw_q;
	logic push, full, pop, empty;
	c128b_pkg::entry_t push_entry, head;
	logic [5:0] element_width;

	assign cfg_ready = 1'b1;

	// module width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mw_q <= 4'd2;
		else if (cfg_valid && cfg_ready) mw_q <= cfg_data;
	end

	c128b_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.char_code  (s_tdata[6:0]),
		.first_char (s_tuser[0]),
		.last_char  (s_tlast),
		.push       (push),
		.full       (full),
		.push_entry (push_entry)
	);

	c128b_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	c128b_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.module_width  (mw_q),
		.empty         (empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.element_width (element_width),
		.is_bar        (m_tuser[0]),
		.end_of_code   (m_tuser[1]),
		.bad_char      (m_tuser[2]),
		.last_of_run   (m_tlast)
	);

	assign m_tdata = {2'b00, element_width};

endmodule
